/* hw/rtl/aopq_pkg.sv */
`default_nettype none
package aopq_pkg;

  localparam int TRACKS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;

  localparam int MODE_W = 2;
  localparam int TRK_W  = 3;
  localparam int ID_W   = 22;
  localparam int PRIO_W = 2;

  localparam int TIDX_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = TIDX_W + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int PROD_W    = TIME_BITS + PRIO_W;

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISP = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TRK_W-1:0]  track;
    logic [ID_W-1:0]   train_id;
    logic [PRIO_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic             granted;
    logic [TRK_W-1:0] granted_track;
    logic [ID_W-1:0]  granted_id;
    logic             status;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_W-1:0]    prio;
    logic [TIME_BITS-1:0] tick;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_GRANT
  } state_t;

  // tag of a head read issued this cycle
  typedef struct packed {
    logic              clear;
    logic              vld;
    logic [TIDX_W-1:0] trk;
  } probe_t;

  typedef struct packed {
    logic              found;
    logic [TIDX_W-1:0] trk;
    logic [ID_W-1:0]   id;
  } best_t;

endpackage
`default_nettype wire

/* hw/rtl/aopq_entry_ram.sv */
`default_nettype none
module aopq_entry_ram (
  input  wire                      clk,
  input  wire                      we,
  input  wire [aopq_pkg::ADDR_W-1:0] waddr,
  input  aopq_pkg::entry_t         wdata,
  input  wire [aopq_pkg::ADDR_W-1:0] raddr,
  output aopq_pkg::entry_t         rdata
);
  import aopq_pkg::*;

  entry_t mem [RAM_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hw/rtl/aopq_score.sv */
`default_nettype none
module aopq_score (
  input  wire                         clk,
  input  wire                         rst_n,
  input  aopq_pkg::probe_t            probe,
  input  aopq_pkg::entry_t            rdata,
  input  wire [aopq_pkg::TIME_BITS-1:0] now_ticks,
  output aopq_pkg::best_t             best
);
  import aopq_pkg::*;

  logic                 tag_vld_r;
  logic [TIDX_W-1:0]    tag_trk_r;
  logic [TIME_BITS-1:0] best_wait_r;
  logic [PRIO_W-1:0]    best_prio_r;
  logic                 found_r;
  logic [TIDX_W-1:0]    best_trk_r;
  logic [ID_W-1:0]      best_id_r;

  logic [TIME_BITS-1:0] wait_cur;
  logic [PROD_W-1:0]    lhs;
  logic [PROD_W-1:0]    rhs;
  logic                 win;

  // wait * best_prio > best_wait * prio, strict
  always_comb begin
    wait_cur = now_ticks - rdata.tick;
    lhs      = PROD_W'(wait_cur) * PROD_W'(best_prio_r);
    rhs      = PROD_W'(best_wait_r) * PROD_W'(rdata.prio);
    win      = tag_vld_r && (rdata.prio != '0) && (lhs > rhs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= probe.vld;
    end
  end

  always_ff @(posedge clk) begin
    tag_trk_r <= probe.trk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (probe.clear) begin
      found_r <= 1'b0;
    end else if (win) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (probe.clear) begin
      best_wait_r <= '0;
      best_prio_r <= PRIO_W'(1);
      best_trk_r  <= '0;
      best_id_r   <= '0;
    end else if (win) begin
      best_wait_r <= wait_cur;
      best_prio_r <= rdata.prio;
      best_trk_r  <= tag_trk_r;
      best_id_r   <= rdata.id;
    end
  end

  assign best = '{found: found_r, trk: best_trk_r, id: best_id_r};

endmodule
`default_nettype wire

/* hw/rtl/aopq_ctrl.sv */
`default_nettype none
module aopq_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  aopq_pkg::in_word_t          in_word,
  output logic                        out_strobe,
  output aopq_pkg::out_word_t         out_word,
  output logic                        ram_we,
  output logic [aopq_pkg::ADDR_W-1:0] ram_waddr,
  output aopq_pkg::entry_t            ram_wdata,
  output logic [aopq_pkg::ADDR_W-1:0] ram_raddr,
  output aopq_pkg::probe_t            probe,
  output logic [aopq_pkg::TIME_BITS-1:0] now_ticks,
  input  aopq_pkg::best_t             best
);
  import aopq_pkg::*;

  state_t               state_r, state_nxt;
  logic [TIDX_W-1:0]    scan_r, scan_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic [PTR_W-1:0] head_r [TRACKS];
  logic [PTR_W-1:0] tail_r [TRACKS];
  logic [OCC_W-1:0] occ_r  [TRACKS];

  logic [TIDX_W-1:0] idx;
  logic [PTR_W-1:0]  head_sel, tail_sel;
  logic [OCC_W-1:0]  occ_sel;
  logic              head_we, tail_we, occ_we;
  logic [PTR_W-1:0]  head_nxt, tail_nxt;
  logic [OCC_W-1:0]  occ_nxt;
  logic              acc, trk_oob, drop;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    case (state_r)
      ST_SCAN:  idx = scan_r;
      ST_GRANT: idx = best.trk;
      default:  idx = TIDX_W'(in_word.track);
    endcase
    head_sel = head_r[idx];
    tail_sel = tail_r[idx];
    occ_sel  = occ_r[idx];
  end

  always_comb begin
    acc     = start && (state_r == ST_IDLE);
    trk_oob = 32'(in_word.track) >= TRACKS;
    drop    = trk_oob || (occ_sel == OCC_W'(QUEUE_DEPTH));

    state_nxt      = state_r;
    scan_nxt       = scan_r;
    now_nxt        = now_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;
    head_we        = 1'b0;
    tail_we        = 1'b0;
    occ_we         = 1'b0;
    head_nxt       = next_slot(head_sel);
    tail_nxt       = next_slot(tail_sel);
    occ_nxt        = occ_sel;
    ram_we         = 1'b0;
    ram_waddr      = {idx, tail_sel};
    ram_wdata      = '{id: in_word.train_id, prio: in_word.priority_req, tick: now_r};
    ram_raddr      = {idx, head_sel};
    probe          = '0;
    probe.trk      = scan_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_word.mode)
            MODE_ENQ: begin
              out_strobe_nxt      = 1'b1;
              out_word_nxt.status = drop ? STATUS_DROP : STATUS_OK;
              if (!drop) begin
                ram_we  = 1'b1;
                tail_we = 1'b1;
                occ_we  = 1'b1;
                occ_nxt = occ_sel + OCC_W'(1);
              end
            end
            MODE_TICK: begin
              out_strobe_nxt = 1'b1;
              now_nxt        = now_r + TIME_BITS'(1);
            end
            MODE_DISP: begin
              probe.clear = 1'b1;
              scan_nxt    = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        probe.vld = (occ_sel != '0);
        if (scan_r == TIDX_W'(TRACKS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_nxt = scan_r + TIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_GRANT;
      end
      ST_GRANT: begin
        out_strobe_nxt = 1'b1;
        if (best.found) begin
          head_we                    = 1'b1;
          occ_we                     = 1'b1;
          occ_nxt                    = occ_sel - OCC_W'(1);
          out_word_nxt.granted       = 1'b1;
          out_word_nxt.granted_track = TRK_W'(best.trk);
          out_word_nxt.granted_id    = best.id;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_r       <= '0;
      now_r        <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        occ_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      now_r        <= now_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (head_we) begin
        head_r[idx] <= head_nxt;
      end
      if (tail_we) begin
        tail_r[idx] <= tail_nxt;
      end
      if (occ_we) begin
        occ_r[idx] <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;
  assign now_ticks  = now_r;

  a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT && best.found) |-> (occ_sel != '0))
    else $error("grant from empty track");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_r == TIDX_W'(TRACKS - 1)) |=> (state_r == ST_DRAIN))
    else $error("scan did not end at last track");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (occ_sel < OCC_W'(QUEUE_DEPTH)))
    else $error("write into full track");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r == ST_GRANT)
                      || $past(acc && in_word.mode != MODE_DISP)))
    else $error("word without cause");

endmodule
`default_nettype wire

/* hw/rtl/age_over_priority_queue_arbiter.sv */
// Channel   Ports                    Handshake
// input     start, busy, in_word     taken when start && !busy
// result    out_strobe, out_word     valid for the single cycle out_strobe is high
//
// Enqueue, tick and unused mode are handled in idle; the word shows the cycle after.
// Dispatch keeps busy high through scan (one entry RAM read per track head), drain
// (compare the last head) and grant (dequeue); the word shows the cycle after.
// Reset is synchronous, active low; pointers, counts and tick clear at once,
// the entry RAM is not cleared. The receiver cannot stall the result.
`default_nettype none
module age_over_priority_queue_arbiter (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  aopq_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output aopq_pkg::out_word_t out_word
);
  import aopq_pkg::*;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  entry_t               ram_rdata;
  probe_t               probe;
  best_t                best;
  logic [TIME_BITS-1:0] now_ticks;

  aopq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .probe      (probe),
    .now_ticks  (now_ticks),
    .best       (best)
  );

  aopq_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aopq_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .probe     (probe),
    .rdata     (ram_rdata),
    .now_ticks (now_ticks),
    .best      (best)
  );

endmodule
`default_nettype wire
